// ===== rtl/core/kruskal_minimum_spanning_tree_assert.svh =====
// Assertion macros for the checker file of the spanning tree block.
// Needs nothing else; include by bare file name.
`ifndef KRUSKAL_MINIMUM_SPANNING_TREE_ASSERT_SVH
`define KRUSKAL_MINIMUM_SPANNING_TREE_ASSERT_SVH

// Same-cycle implication
`define KMST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define KMST_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/kmst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the spanning tree block.
// No dependencies.
package kmst_pkg;

   localparam int DEF_MAX_VERTS = 64;
   localparam int DEF_MAX_EDGES = 256;
   localparam int WEIGHT_BITS   = 16;
   localparam int VERT_BITS     = 6;
   localparam int CFG_BITS      = 7;
   localparam int RANK_BITS     = 3;

   localparam logic [RANK_BITS-1:0] RANK_MAX  = 3'd7;
   localparam logic [CFG_BITS-1:0]  CFG_RESET = 7'd64;

   typedef logic [VERT_BITS-1:0]          vert_type;
   typedef logic signed [WEIGHT_BITS-1:0] wt_type;
   typedef logic [RANK_BITS-1:0]          rank_type;

   typedef struct packed {
      vert_type edge_src;
      vert_type edge_dst;
      wt_type   edge_wt;
      logic     last_edge;
   } req_beat_type;

   typedef struct packed {
      vert_type tree_src;
      vert_type tree_dst;
      wt_type   tree_wt;
      logic     run_end;
      logic     none;
      logic     dropped;
   } rsp_beat_type;

   // one stored edge
   typedef struct packed {
      vert_type src;
      vert_type dst;
      wt_type   wt;
   } edge_type;

   // command to the forest unit, single-cycle pulse
   typedef struct packed {
      logic     clear;
      logic     link;
      vert_type va;
      vert_type vb;
   } frst_cmd_type;

   // forest status: done pulses once per command
   typedef struct packed {
      logic done;
      logic joined;
   } frst_sts_type;

endpackage

// ===== rtl/core/kmst_forest.sv =====
`timescale 1ns / 1ps
// Disjoint-set forest: parent and rank memories, find with path compression,
// union by rank. Depends on kmst_pkg.
module kmst_forest #(
   parameter int MAX_VERTS = kmst_pkg::DEF_MAX_VERTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kmst_pkg::frst_cmd_type cmd,
   output kmst_pkg::frst_sts_type sts
);

   localparam int VW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
   localparam logic [VW-1:0] LAST_V = VW'(MAX_VERTS - 1);

   typedef enum logic [3:0] {
      F_IDLE, F_CLR, F_FRD, F_FCHK, F_CRD, F_CCHK, F_RKA, F_RKB, F_JOIN
   } state_type;

   state_type state_ff;
   logic [VW-1:0] cur_ff, start_ff, root_ff, ra_ff, vb_ff, clr_ff;
   logic          side_ff;
   logic          done_ff, joined_ff;
   logic          done_in;
   kmst_pkg::rank_type rank_a_ff;

   // memories
   logic [VW-1:0]      parent_mem [MAX_VERTS];
   kmst_pkg::rank_type rank_mem   [MAX_VERTS];
   logic [VW-1:0]      par_rd_ff;
   kmst_pkg::rank_type rk_rd_ff;

   logic               par_we, rk_we;
   logic [VW-1:0]      par_waddr, par_wdata, rk_waddr, rk_raddr;
   kmst_pkg::rank_type rk_wdata;

   // write and read port control
   always_comb begin
      par_we    = 1'b0;
      par_waddr = clr_ff;
      par_wdata = clr_ff;
      rk_we     = 1'b0;
      rk_waddr  = clr_ff;
      rk_wdata  = '0;
      rk_raddr  = (state_ff == F_RKA) ? ra_ff : root_ff;
      case (state_ff)
         F_CLR: begin
            par_we = 1'b1;
            rk_we  = 1'b1;
         end
         F_CCHK: begin
            // compress: point the walked vertex straight at its root
            if (par_rd_ff != root_ff) begin
               par_we    = 1'b1;
               par_waddr = cur_ff;
               par_wdata = root_ff;
            end
         end
         F_JOIN: begin
            par_we = 1'b1;
            if (rank_a_ff > rk_rd_ff) begin
               par_waddr = root_ff;
               par_wdata = ra_ff;
            end else begin
               par_waddr = ra_ff;
               par_wdata = root_ff;
               if (rank_a_ff == rk_rd_ff && rk_rd_ff < kmst_pkg::RANK_MAX) begin
                  rk_we    = 1'b1;
                  rk_waddr = root_ff;
                  rk_wdata = rk_rd_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // done pulse: clear pass finished, same set found, or union written
   assign done_in = ((state_ff == F_CLR) && (clr_ff == LAST_V))
                    || ((state_ff == F_CCHK) && (par_rd_ff == root_ff) && side_ff
                        && (root_ff == ra_ff))
                    || (state_ff == F_JOIN);

   always_ff @(posedge clock) begin
      if (par_we) parent_mem[par_waddr] <= par_wdata;
      par_rd_ff <= parent_mem[cur_ff];
      if (rk_we) rank_mem[rk_waddr] <= rk_wdata;
      rk_rd_ff <= rank_mem[rk_raddr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         done_ff   <= 1'b0;
         joined_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         case (state_ff)
            F_IDLE: begin
               if (cmd.clear) begin
                  clr_ff   <= '0;
                  state_ff <= F_CLR;
               end else if (cmd.link) begin
                  cur_ff   <= VW'(cmd.va);
                  start_ff <= VW'(cmd.va);
                  vb_ff    <= VW'(cmd.vb);
                  side_ff  <= 1'b0;
                  state_ff <= F_FRD;
               end
            end
            F_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_V) begin
                  joined_ff <= 1'b0;
                  state_ff  <= F_IDLE;
               end
            end
            F_FRD: state_ff <= F_FCHK;
            F_FCHK: begin
               if (par_rd_ff == cur_ff) begin
                  root_ff  <= cur_ff;
                  cur_ff   <= start_ff;
                  state_ff <= F_CRD;
               end else begin
                  cur_ff   <= par_rd_ff;
                  state_ff <= F_FRD;
               end
            end
            F_CRD: state_ff <= F_CCHK;
            F_CCHK: begin
               if (par_rd_ff == root_ff) begin
                  if (!side_ff) begin
                     ra_ff    <= root_ff;
                     side_ff  <= 1'b1;
                     cur_ff   <= vb_ff;
                     start_ff <= vb_ff;
                     state_ff <= F_FRD;
                  end else if (root_ff == ra_ff) begin
                     joined_ff <= 1'b0;
                     state_ff  <= F_IDLE;
                  end else begin
                     state_ff <= F_RKA;
                  end
               end else begin
                  cur_ff   <= par_rd_ff;
                  state_ff <= F_CRD;
               end
            end
            F_RKA: state_ff <= F_RKB;
            F_RKB: begin
               rank_a_ff <= rk_rd_ff;
               state_ff  <= F_JOIN;
            end
            F_JOIN: begin
               joined_ff <= 1'b1;
               state_ff  <= F_IDLE;
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign sts.done   = done_ff;
   assign sts.joined = joined_ff;

endmodule

// ===== rtl/core/kruskal_minimum_spanning_tree.sv =====
`timescale 1ns / 1ps
// Top level of the spanning tree block: edge memory, weight-order scan,
// result staging. Depends on kmst_pkg and kmst_forest.
//
// Edges load at one beat per cycle while the block is idle into an edge
// memory with one write and one read port. The beat marked last starts a
// run and the input stalls until the final result of the run is in the
// output register. A run clears the forest, then for each edge taken in
// weight order scans all n stored edges through the edge memory read port
// and runs a find on both endpoints in the parent memory (walk plus
// compression pass on each side), then hands off and, for an edge that
// joins two trees, writes the union and emits the edge. A run ends early
// when the tree completes.
module kruskal_minimum_spanning_tree #(
   parameter int MAX_VERTS = kmst_pkg::DEF_MAX_VERTS,
   parameter int MAX_EDGES = kmst_pkg::DEF_MAX_EDGES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  kmst_pkg::req_beat_type     req_beat,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output kmst_pkg::rsp_beat_type     rsp_beat,
   input  logic                       csr_wr_en,
   input  logic [kmst_pkg::CFG_BITS-1:0] csr_wr_data
);

   localparam int AW  = $clog2(MAX_EDGES);
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int NV1 = $clog2(MAX_VERTS + 1);
   localparam int NW  = (NV1 > kmst_pkg::CFG_BITS) ? NV1 : kmst_pkg::CFG_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_CLR, S_SEL, S_SCAN, S_FIND, S_EMIT, S_FINISH
   } state_type;

   state_type state_ff;
   logic [kmst_pkg::CFG_BITS-1:0] csr_ff;
   logic [EW-1:0]      cnt_ff, sel_ff, iss_ff, didx_ff, bidx_ff, pidx_ff;
   logic               drop_ff, dv_ff, bestv_ff, prevv_ff, pendv_ff;
   logic [NW-1:0]      acc_ff;
   kmst_pkg::edge_type best_ff, pend_ff, edge_rd_ff;
   kmst_pkg::wt_type   pwt_ff;
   kmst_pkg::frst_cmd_type cmd_ff;
   kmst_pkg::frst_sts_type sts;
   logic               rsp_valid_ff;
   kmst_pkg::rsp_beat_type rsp_beat_ff;

   kmst_pkg::edge_type edge_mem [MAX_EDGES];

   logic [NW-1:0] nv;
   logic          req_accept, store_ok, out_free, after_prev, before_best;
   logic          clear_in, link_in, rsp_load, rsp_valid_in;

   // effective vertex count: zero acts as one, clamp to capacity
   always_comb begin
      if (csr_ff == '0)
         nv = NW'(1);
      else if (NW'(csr_ff) > NW'(MAX_VERTS))
         nv = NW'(MAX_VERTS);
      else
         nv = NW'(csr_ff);
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign store_ok   = (NW'(req_beat.edge_src) < nv) && (NW'(req_beat.edge_dst) < nv)
                       && (cnt_ff < EW'(MAX_EDGES));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // forest command pulses and output register load
   assign clear_in     = req_accept && req_beat.last_edge;
   assign link_in      = (state_ff == S_SCAN) && (iss_ff == cnt_ff) && !dv_ff;
   assign rsp_load     = out_free && (((state_ff == S_EMIT) && pendv_ff)
                                      || (state_ff == S_FINISH));
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // scan compare: candidate comes after the previous pick, before the best
   assign after_prev  = !prevv_ff || (edge_rd_ff.wt > pwt_ff)
                        || ((edge_rd_ff.wt == pwt_ff) && (didx_ff > pidx_ff));
   assign before_best = !bestv_ff || (edge_rd_ff.wt < best_ff.wt);

   // edge memory
   always_ff @(posedge clock) begin
      if (req_accept && store_ok)
         edge_mem[cnt_ff[AW-1:0]] <= '{src: req_beat.edge_src, dst: req_beat.edge_dst,
                                       wt: req_beat.edge_wt};
      edge_rd_ff <= edge_mem[iss_ff[AW-1:0]];
   end

   kmst_forest #(.MAX_VERTS(MAX_VERTS)) u_forest (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .sts   (sts)
   );

   // control sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_ff       <= kmst_pkg::CFG_RESET;
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pendv_ff     <= 1'b0;
         dv_ff        <= 1'b0;
      end else begin
         cmd_ff.clear <= clear_in;
         cmd_ff.link  <= link_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) csr_ff <= csr_wr_data;
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  if (store_ok) cnt_ff <= cnt_ff + 1'b1;
                  else          drop_ff <= 1'b1;
                  if (req_beat.last_edge) begin
                     sel_ff       <= '0;
                     acc_ff       <= '0;
                     prevv_ff     <= 1'b0;
                     pendv_ff     <= 1'b0;
                     state_ff     <= S_CLR;
                  end
               end
            end
            S_CLR: begin
               if (sts.done) state_ff <= S_SEL;
            end
            S_SEL: begin
               if (sel_ff == cnt_ff || (acc_ff + 1'b1) >= nv) begin
                  state_ff <= S_FINISH;
               end else begin
                  iss_ff   <= '0;
                  dv_ff    <= 1'b0;
                  bestv_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // issue one read a cycle, compare the data of the last one
               if (iss_ff != cnt_ff) begin
                  iss_ff  <= iss_ff + 1'b1;
                  didx_ff <= iss_ff;
                  dv_ff   <= 1'b1;
               end else begin
                  dv_ff <= 1'b0;
               end
               if (dv_ff && after_prev && before_best) begin
                  best_ff  <= edge_rd_ff;
                  bidx_ff  <= didx_ff;
                  bestv_ff <= 1'b1;
               end
               if (iss_ff == cnt_ff && !dv_ff) begin
                  prevv_ff    <= 1'b1;
                  pwt_ff      <= best_ff.wt;
                  pidx_ff     <= bidx_ff;
                  sel_ff      <= sel_ff + 1'b1;
                  cmd_ff.va   <= best_ff.src;
                  cmd_ff.vb   <= best_ff.dst;
                  state_ff    <= S_FIND;
               end
            end
            S_FIND: begin
               if (sts.done) state_ff <= sts.joined ? S_EMIT : S_SEL;
            end
            S_EMIT: begin
               // hold one tree edge back so the last one can carry run_end
               if (!pendv_ff || out_free) begin
                  if (pendv_ff) begin
                     rsp_beat_ff  <= '{tree_src: pend_ff.src, tree_dst: pend_ff.dst,
                                       tree_wt: pend_ff.wt, run_end: 1'b0, none: 1'b0,
                                       dropped: drop_ff};
                  end
                  pend_ff  <= best_ff;
                  pendv_ff <= 1'b1;
                  acc_ff   <= acc_ff + 1'b1;
                  state_ff <= S_SEL;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  if (pendv_ff)
                     rsp_beat_ff <= '{tree_src: pend_ff.src, tree_dst: pend_ff.dst,
                                      tree_wt: pend_ff.wt, run_end: 1'b1, none: 1'b0,
                                      dropped: drop_ff};
                  else
                     rsp_beat_ff <= '{tree_src: '0, tree_dst: '0, tree_wt: '0,
                                      run_end: 1'b1, none: 1'b1, dropped: drop_ff};
                  pendv_ff <= 1'b0;
                  cnt_ff   <= '0;
                  drop_ff  <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

// ===== rtl/core/kmst_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the spanning tree block, bound to the top level.
// Depends on kmst_pkg and kruskal_minimum_spanning_tree_assert.svh.
`include "kruskal_minimum_spanning_tree_assert.svh"

module kmst_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input kmst_pkg::req_beat_type        req_beat,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input kmst_pkg::rsp_beat_type        rsp_beat
);

   // a stalled result beat holds
   `KMST_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat), "rsp beat changed under stall")

   // the last edge starts a run, input stalls next cycle
   `KMST_ASSERT_NXT(a_run_starts, clock, reset, req_valid && !req_stall && req_beat.last_edge, req_stall, "no stall after last edge")

   // a new result appears only out of a run
   `KMST_ASSERT_IMP(a_rsp_in_run, clock, reset, $rose(rsp_valid), $past(req_stall), "result outside a run")

   // a result other than the final one is shown only while the run is busy
   `KMST_ASSERT_IMP(a_mid_run, clock, reset, rsp_valid && !rsp_beat.run_end, req_stall, "mid-run result while idle")

endmodule

bind kruskal_minimum_spanning_tree kmst_checker u_kmst_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of kruskal_minimum_spanning_tree: edge beats in,
// tree edges out, each result checked against an in-bench spanning tree
// predictor. Depends on kmst_pkg and the block's RTL.
module tb_top;

   localparam int IDLE_LIMIT = 250000;

   typedef struct {
      kmst_pkg::vert_type src;
      kmst_pkg::vert_type dst;
      kmst_pkg::wt_type   wt;
   } held_edge_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   kmst_pkg::req_beat_type req_beat;
   logic         rsp_valid;
   logic         rsp_stall;
   kmst_pkg::rsp_beat_type rsp_beat;
   logic         csr_wr_en;
   logic [kmst_pkg::CFG_BITS-1:0] csr_wr_data;

   // predictor state
   held_edge_type graph_edges[$];
   bit            graph_dropped;
   int            vcount_shadow;
   kmst_pkg::rsp_beat_type tree_due[$];

   int  error_count;
   int  rsp_idle_left;
   int  rsp_hold_left;
   bit  quiet;
   int  idle_cycles;

   kruskal_minimum_spanning_tree dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_beat    (req_beat),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Kruskal over the held graph: stable sort by weight, then union-find
   function automatic void build_tree(int nv);
      int order[$];
      int parent[kmst_pkg::DEF_MAX_VERTS];
      int rnk[kmst_pkg::DEF_MAX_VERTS];
      int j, tmp, ra, rb, taken;
      kmst_pkg::rsp_beat_type r;
      for (int i = 0; i < kmst_pkg::DEF_MAX_VERTS; i++) begin
         parent[i] = i;
         rnk[i] = 0;
      end
      for (int i = 0; i < graph_edges.size(); i++) begin
         order.insert(order.size(), i);
         j = i;
         while (j > 0 && graph_edges[order[j-1]].wt > graph_edges[order[j]].wt) begin
            tmp = order[j];
            order[j] = order[j-1];
            order[j-1] = tmp;
            j--;
         end
      end
      taken = 0;
      for (int i = 0; i < order.size() && taken + 1 < nv; i++) begin
         ra = graph_edges[order[i]].src;
         rb = graph_edges[order[i]].dst;
         while (parent[ra] != ra) ra = parent[ra];
         while (parent[rb] != rb) rb = parent[rb];
         if (ra == rb) continue;
         if (rnk[ra] > rnk[rb]) parent[rb] = ra;
         else if (rnk[ra] < rnk[rb]) parent[ra] = rb;
         else begin
            parent[ra] = rb;
            if (rnk[rb] < 7) rnk[rb]++;
         end
         r = '0;
         r.tree_src = graph_edges[order[i]].src;
         r.tree_dst = graph_edges[order[i]].dst;
         r.tree_wt  = graph_edges[order[i]].wt;
         r.dropped  = graph_dropped;
         tree_due.insert(tree_due.size(), r);
         taken++;
      end
      if (taken == 0) begin
         r = '0;
         r.none    = 1'b1;
         r.dropped = graph_dropped;
         tree_due.insert(tree_due.size(), r);
      end
      tree_due[tree_due.size()-1].run_end = 1'b1;
      graph_edges.delete();
      graph_dropped = 1'b0;
   endfunction

   function automatic void predict_edge(kmst_pkg::req_beat_type b);
      int nv;
      held_edge_type e;
      nv = (vcount_shadow < 1) ? 1 :
           (vcount_shadow > kmst_pkg::DEF_MAX_VERTS) ? kmst_pkg::DEF_MAX_VERTS
                                                     : vcount_shadow;
      if (b.edge_src >= nv || b.edge_dst >= nv
          || graph_edges.size() >= kmst_pkg::DEF_MAX_EDGES)
         graph_dropped = 1'b1;
      else begin
         e.src = b.edge_src;
         e.dst = b.edge_dst;
         e.wt  = b.edge_wt;
         graph_edges.insert(graph_edges.size(), e);
      end
      if (b.last_edge) build_tree(nv);
   endfunction

   // send one edge beat; valid stays high for a following beat, save for random gaps when not quiet
   task automatic send_edge(int s, int d, int w, bit last);
      kmst_pkg::req_beat_type b;
      b.edge_src  = kmst_pkg::vert_type'(s);
      b.edge_dst  = kmst_pkg::vert_type'(d);
      b.edge_wt   = kmst_pkg::wt_type'(w);
      b.last_edge = last;
      req_beat  <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_edge(b);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tree_due.size() != 0) @(posedge clock);
   endtask

   // register write only with the block idle
   task automatic write_vcount(int v);
      drain();
      repeat (20) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= kmst_pkg::CFG_BITS'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vcount_shadow = v;
   endtask

   task automatic random_graph(int n, int nv, int wspan);
      int s, d;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            s = $urandom_range(0, 63);
            d = $urandom_range(0, 63);
         end else begin
            s = $urandom_range(0, nv - 1);
            d = $urandom_range(0, nv - 1);
         end
         send_edge(s, d, $urandom_range(0, wspan) - wspan / 2, i == n - 1);
      end
   endtask

   task automatic test_extremes();
      send_edge(0, 63, 32767, 0);
      send_edge(63, 0, -32768, 0);
      send_edge(5, 5, -32768, 0);
      send_edge(1, 2, 100, 0);
      send_edge(2, 3, 100, 0);
      send_edge(1, 3, 100, 0);
      send_edge(42, 21, 0, 1);
      drain();
      send_edge(7, 7, -1, 1);
   endtask

   task automatic test_range_drop();
      write_vcount(0);
      send_edge(0, 1, 3, 0);
      send_edge(0, 0, 4, 1);
      drain();
      send_edge(1, 0, 4, 1);
      write_vcount(1);
      send_edge(0, 0, 9, 1);
      write_vcount(127);
      send_edge(63, 62, -5, 0);
      send_edge(62, 61, -6, 1);
      write_vcount(2);
      send_edge(0, 1, 8, 0);
      send_edge(1, 0, 2, 0);
      send_edge(1, 2, 1, 1);
   endtask

   task automatic test_backpressure();
      write_vcount(8);
      rsp_hold_left = 400;
      random_graph(6, 8, 40);
      random_graph(6, 8, 40);
      random_graph(5, 8, 40);
      drain();
   endtask

   task automatic test_random();
      int nv;
      for (int g = 0; g < 22; g++) begin
         nv = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 127) : $urandom_range(2, 12);
         write_vcount(nv);
         if (g >= 18) quiet = 1'b1;
         random_graph($urandom_range(1, 12), (nv > 64) ? 64 : (nv < 1) ? 1 : nv,
                      ($urandom_range(0, 1) != 0) ? 65535 : 8);
      end
   endtask

   // response stall: random bursts, a long hold when asked, none when quiet
   initial begin
      rsp_stall = 1'b0;
      rsp_idle_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (rsp_idle_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_idle_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 5) == 0) rsp_idle_left = $urandom_range(1, 14);
         end
      end
   end

   // result check against the oldest predicted tree edge
   always @(posedge clock) begin
      kmst_pkg::rsp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tree_due.size() == 0) begin
            $error("unexpected result beat %h", rsp_beat);
            error_count++;
         end else begin
            want = tree_due.pop_front();
            if (rsp_beat.tree_src !== want.tree_src) begin
               $error("tree_src expected %0d actual %0d", want.tree_src, rsp_beat.tree_src);
               error_count++;
            end
            if (rsp_beat.tree_dst !== want.tree_dst) begin
               $error("tree_dst expected %0d actual %0d", want.tree_dst, rsp_beat.tree_dst);
               error_count++;
            end
            if (rsp_beat.tree_wt !== want.tree_wt) begin
               $error("tree_wt expected %0d actual %0d", want.tree_wt, rsp_beat.tree_wt);
               error_count++;
            end
            if (rsp_beat.run_end !== want.run_end) begin
               $error("run_end expected %0b actual %0b", want.run_end, rsp_beat.run_end);
               error_count++;
            end
            if (rsp_beat.none !== want.none) begin
               $error("none expected %0b actual %0b", want.none, rsp_beat.none);
               error_count++;
            end
            if (rsp_beat.dropped !== want.dropped) begin
               $error("dropped expected %0b actual %0b", want.dropped, rsp_beat.dropped);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any beat moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("kruskal_minimum_spanning_tree regression: fail");
         $finish;
      end
   end

   initial begin
      error_count   = 0;
      idle_cycles   = 0;
      quiet         = 1'b0;
      rsp_hold_left = 0;
      vcount_shadow = kmst_pkg::CFG_RESET;
      graph_dropped = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_beat    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);
      test_extremes();
      test_range_drop();
      test_backpressure();
      test_random();
      drain();
      repeat (200) @(posedge clock);
      if (error_count == 0 && tree_due.size() == 0)
         $display("kruskal_minimum_spanning_tree regression: pass");
      else
         $display("kruskal_minimum_spanning_tree regression: fail");
      $finish;
   end

endmodule
